@@ src/bqmix_pkg.sv @@
// shared types and constants for the biquad section with wet/dry mix
package bqmix_pkg;

    // default sizes
    localparam int DEF_SAMPLE_BITS    = 24;
    localparam int DEF_COEF_BITS      = 32;
    localparam int DEF_COEF_FRAC_BITS = 27;

    // width of the internal value and the delay line
    localparam int STATE_BITS = 32;

    // register file
    localparam int NUM_REGS = 7;
    localparam int REG_IDX_W = 3;

    localparam logic [REG_IDX_W-1:0] REG_FF_COEF_0 = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_FF_COEF_1 = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_FF_COEF_2 = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_FB_COEF_1 = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_FB_COEF_2 = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_WET_GAIN  = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_DRY_GAIN  = 3'd6;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CALC,
        ST_DELIVER
    } bq_state_t;

    // accumulator operations
    typedef enum logic [2:0] {
        ACC_HOLD,
        ACC_LOAD_X,
        ACC_LOAD_P,
        ACC_ADD,
        ACC_SUB
    } acc_op_t;

    // multiplier operand selects
    typedef enum logic [1:0] {
        MB_DELAY_FIRST,
        MB_DELAY_SECOND,
        MB_W,
        MB_Y
    } mul_b_sel_t;

    // steps of one sample
    localparam int STEP_W = 4;
    localparam logic [STEP_W-1:0] STEP_FB1    = 4'd0;
    localparam logic [STEP_W-1:0] STEP_FB2    = 4'd1;
    localparam logic [STEP_W-1:0] STEP_FF1    = 4'd2;
    localparam logic [STEP_W-1:0] STEP_W_RND  = 4'd3;
    localparam logic [STEP_W-1:0] STEP_FF0    = 4'd4;
    localparam logic [STEP_W-1:0] STEP_DRY    = 4'd5;
    localparam logic [STEP_W-1:0] STEP_Y_RND  = 4'd6;
    localparam logic [STEP_W-1:0] STEP_WET    = 4'd7;
    localparam logic [STEP_W-1:0] STEP_MIX    = 4'd8;

endpackage

@@ src/biquad_filter_with_wet_dry_mix.sv @@
// biquad section (direct form II) with wet/dry mix on one shared multiplier
//
//  channel  | dir | handshake                     | payload
//  ---------+-----+-------------------------------+-------------------------------
//  s_axis   | in  | s_axis_tvalid / s_axis_tready | s_axis_tdata: sample_in
//  m_axis   | out | m_axis_tvalid / m_axis_tready | m_axis_tdata: sample_out
//  apb      | in  | psel / penable / pready       | paddr, pwdata, prdata: coefs
//
//  each accepted sample runs 9 steps on the single coef x state
//  multiplier and accumulator, then a rounding/delivery state; the next
//  sample is taken the cycle after the result is registered, so a new
//  sample is accepted only once the previous result has been delivered.
//  a result waiting in the output register stalls only the delivery state.
//  reset clears the delay line and loads pass-through coefficients.
module biquad_filter_with_wet_dry_mix #(
    parameter int SAMPLE_BITS    = bqmix_pkg::DEF_SAMPLE_BITS,
    parameter int COEF_BITS      = bqmix_pkg::DEF_COEF_BITS,
    parameter int COEF_FRAC_BITS = bqmix_pkg::DEF_COEF_FRAC_BITS,
    localparam int TDATA_W  = ((SAMPLE_BITS + 7) / 8) * 8,
    localparam int PDATA_W  = (COEF_BITS > 32) ? 64 : 32,
    localparam int PADDR_W  = (COEF_BITS > 32) ? 6 : 5
) (
    input  logic               clk,
    input  logic               rst_n,
    // stream in
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [TDATA_W-1:0] s_axis_tdata,   // [SAMPLE_BITS-1:0] sample_in
    // stream out
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [TDATA_W-1:0] m_axis_tdata,   // [SAMPLE_BITS-1:0] sample_out
    // register port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);
    import bqmix_pkg::*;

    localparam int ADDR_LSB = (COEF_BITS > 32) ? 3 : 2;
    localparam int PROD_W   = COEF_BITS + STATE_BITS;
    localparam int ACC_W    = PROD_W + 2;
    localparam logic signed [COEF_BITS-1:0] COEF_ONE =
        {{(COEF_BITS-1){1'b0}}, 1'b1} << COEF_FRAC_BITS;
    localparam logic signed [ACC_W-1:0] ROUND_ADD =
        {{(ACC_W-1){1'b0}}, 1'b1} << (COEF_FRAC_BITS - 1);

    // registers
    logic signed [COEF_BITS-1:0]   coef_reg [NUM_REGS];
    bq_state_t                     state_reg, state_next;
    logic [STEP_W-1:0]             step_reg, step_next;
    logic signed [SAMPLE_BITS-1:0] x_reg;
    logic signed [STATE_BITS-1:0]  delay_first_reg, delay_second_reg;
    logic signed [STATE_BITS-1:0]  w_reg, y_reg;
    logic signed [PROD_W-1:0]      prod_reg;
    logic signed [ACC_W-1:0]       acc_reg, acc_next;
    logic                          out_valid_reg;
    logic signed [SAMPLE_BITS-1:0] out_reg;

    // control
    logic                          in_beat, cfg_wr, deliver, w_load, y_load;
    logic [REG_IDX_W-1:0]          cfg_idx;
    acc_op_t                       acc_op;
    logic [REG_IDX_W-1:0]          mul_a_idx;
    mul_b_sel_t                    mul_b_sel;
    logic signed [COEF_BITS-1:0]   mul_a;
    logic signed [STATE_BITS-1:0]  mul_b;

    // rounding
    logic signed [ACC_W-1:0]       rnd_sum, rnd;
    logic signed [STATE_BITS-1:0]  rnd_sat_state;
    logic signed [SAMPLE_BITS-1:0] rnd_sat_out;
    logic                          fits_state, fits_out;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite & pready;
    assign cfg_idx = paddr[ADDR_LSB +: REG_IDX_W];
    assign in_beat = s_axis_tvalid & s_axis_tready;

    // register file write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_REGS; i++)
            begin
                coef_reg[i] <= '0;
            end
            coef_reg[REG_FF_COEF_0] <= COEF_ONE;
            coef_reg[REG_WET_GAIN]  <= COEF_ONE;
        end
        else if (cfg_wr && (cfg_idx < REG_IDX_W'(NUM_REGS)))
        begin
            coef_reg[cfg_idx] <= pwdata[COEF_BITS-1:0];
        end
    end

    // register readback
    always_comb
    begin
        case (cfg_idx)
            REG_FF_COEF_0, REG_FF_COEF_1, REG_FF_COEF_2, REG_FB_COEF_1,
            REG_FB_COEF_2, REG_WET_GAIN, REG_DRY_GAIN:
                prdata = PDATA_W'(coef_reg[cfg_idx]);
            default:
                prdata = '0;
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    state_next = ST_CALC;
                    step_next  = STEP_FB1;
                end
            end
            ST_CALC:
            begin
                if (step_reg == STEP_MIX)
                begin
                    state_next = ST_DELIVER;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            ST_DELIVER:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        s_axis_tready = 1'b0;
        deliver       = 1'b0;
        w_load        = 1'b0;
        y_load        = 1'b0;
        acc_op        = ACC_HOLD;
        mul_a_idx     = REG_FB_COEF_1;
        mul_b_sel     = MB_DELAY_FIRST;
        case (state_reg)
            ST_IDLE:
                s_axis_tready = 1'b1;
            ST_CALC:
            begin
                case (step_reg)
                    STEP_FB1:
                    begin
                        acc_op    = ACC_LOAD_X;
                        mul_a_idx = REG_FB_COEF_1;
                        mul_b_sel = MB_DELAY_FIRST;
                    end
                    STEP_FB2:
                    begin
                        acc_op    = ACC_SUB;
                        mul_a_idx = REG_FB_COEF_2;
                        mul_b_sel = MB_DELAY_SECOND;
                    end
                    STEP_FF1:
                    begin
                        acc_op    = ACC_SUB;
                        mul_a_idx = REG_FF_COEF_1;
                        mul_b_sel = MB_DELAY_FIRST;
                    end
                    STEP_W_RND:
                    begin
                        w_load    = 1'b1;
                        acc_op    = ACC_LOAD_P;
                        mul_a_idx = REG_FF_COEF_2;
                        mul_b_sel = MB_DELAY_SECOND;
                    end
                    STEP_FF0:
                    begin
                        acc_op    = ACC_ADD;
                        mul_a_idx = REG_FF_COEF_0;
                        mul_b_sel = MB_W;
                    end
                    STEP_DRY:
                    begin
                        acc_op    = ACC_ADD;
                        mul_a_idx = REG_DRY_GAIN;
                        mul_b_sel = MB_DELAY_FIRST;
                    end
                    STEP_Y_RND:
                    begin
                        y_load = 1'b1;
                        acc_op = ACC_LOAD_P;
                    end
                    STEP_WET:
                    begin
                        mul_a_idx = REG_WET_GAIN;
                        mul_b_sel = MB_Y;
                    end
                    STEP_MIX:
                        acc_op = ACC_ADD;
                    default:
                        acc_op = ACC_HOLD;
                endcase
            end
            ST_DELIVER:
                deliver = !out_valid_reg || m_axis_tready;
            default:
                s_axis_tready = 1'b0;
        endcase
    end

    // shared multiplier operands; the dry step takes x in place of a delay
    always_comb
    begin
        mul_a = coef_reg[mul_a_idx];
        case (mul_b_sel)
            MB_DELAY_FIRST:
                mul_b = (step_reg == STEP_DRY) ? STATE_BITS'(x_reg) : delay_first_reg;
            MB_DELAY_SECOND:
                mul_b = delay_second_reg;
            MB_W:
                mul_b = w_reg;
            MB_Y:
                mul_b = y_reg;
            default:
                mul_b = '0;
        endcase
    end

    // accumulator
    always_comb
    begin
        case (acc_op)
            ACC_LOAD_X:
                acc_next = ACC_W'(x_reg) <<< COEF_FRAC_BITS;
            ACC_LOAD_P:
                acc_next = ACC_W'(prod_reg);
            ACC_ADD:
                acc_next = acc_reg + ACC_W'(prod_reg);
            ACC_SUB:
                acc_next = acc_reg - ACC_W'(prod_reg);
            default:
                acc_next = acc_reg;
        endcase
    end

    // round to nearest, ties up, then saturate
    always_comb
    begin
        rnd_sum    = acc_reg + ROUND_ADD;
        rnd        = rnd_sum >>> COEF_FRAC_BITS;
        fits_state = (rnd[ACC_W-1:STATE_BITS-1] == {(ACC_W-STATE_BITS+1){rnd[ACC_W-1]}});
        fits_out   = (rnd[ACC_W-1:SAMPLE_BITS-1] == {(ACC_W-SAMPLE_BITS+1){rnd[ACC_W-1]}});
        if (fits_state)
        begin
            rnd_sat_state = rnd[STATE_BITS-1:0];
        end
        else
        begin
            rnd_sat_state = {rnd[ACC_W-1], {(STATE_BITS-1){~rnd[ACC_W-1]}}};
        end
        if (fits_out)
        begin
            rnd_sat_out = rnd[SAMPLE_BITS-1:0];
        end
        else
        begin
            rnd_sat_out = {rnd[ACC_W-1], {(SAMPLE_BITS-1){~rnd[ACC_W-1]}}};
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            step_reg         <= STEP_FB1;
            out_valid_reg    <= 1'b0;
            delay_first_reg  <= '0;
            delay_second_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            if (deliver)
            begin
                out_valid_reg    <= 1'b1;
                delay_second_reg <= delay_first_reg;
                delay_first_reg  <= w_reg;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        acc_reg  <= acc_next;
        if (in_beat)
        begin
            x_reg <= s_axis_tdata[SAMPLE_BITS-1:0];
        end
        if (w_load)
        begin
            w_reg <= rnd_sat_state;
        end
        if (y_load)
        begin
            y_reg <= rnd_sat_state;
        end
        if (deliver)
        begin
            out_reg <= rnd_sat_out;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = TDATA_W'($unsigned(out_reg));

    // checks
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        in_beat |=> (state_reg == ST_CALC) && (step_reg == STEP_FB1))
        else $error("accepted beat did not start the sequence");

    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CALC) |-> (step_reg <= STEP_MIX))
        else $error("step counter out of range");

    a_delay_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !deliver |=> $stable(delay_first_reg) && $stable(delay_second_reg))
        else $error("delay line moved without a result");

    a_valid_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(state_reg == ST_DELIVER))
        else $error("result raised outside delivery");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
        else $error("pending result overwritten");

endmodule
